[design/atan2pa_pkg.sv]
// Shared types and constants for the atan2 polynomial approximation core.
// Used by atan2pa_div, atan2pa_poly and atan2_polynomial_approx_core.
`default_nettype none

package atan2pa_pkg;

    // Default field geometry
    localparam int COMP_WIDTH_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // Ratio format: unsigned, 16 fraction bits, one integer bit for 1.0
    localparam int FRAC_W = 16;
    localparam int QUO_W  = FRAC_W + 1;

    // Internal polynomial word: signed, 16 fraction bits
    localparam int PW = 18;

    // Polynomial coefficients, Q0.16
    localparam logic signed [PW-1:0] COEF_C1 = -18'sd3047;
    localparam logic signed [PW-1:0] COEF_C2 = 18'sd10441;
    localparam logic signed [PW-1:0] COEF_C3 = 18'sd21471;

    // pi with 29 fraction bits
    localparam logic [63:0] PI_Q29 = 64'd1686629713;

    // Octant and sign information that rides along with each request
    typedef struct packed {
        logic x_zero;
        logic x_neg;
        logic y_neg;
        logic y_pos;
        logic swap;
    } flags_t;

endpackage

`default_nettype wire

[design/atan2_polynomial_approx_core.sv]
// Top level of the atan2 polynomial approximation core: operand prep, octant fix,
// output register with skid. Depends on atan2pa_pkg, atan2pa_div, atan2pa_poly.
//
//   Channel   Ports                         Dir   Contents
//   input     s_valid s_ready s_y_comp/x    in    signed vector (y, x)
//   result    m_valid m_ready m_angle       out   angle, Q2.13 radians by default
//
// One request per cycle sustained while the skid register is empty; from accept to m_valid the path
// runs through 1 prep stage, 17 divider stages, 6 polynomial stages and 1 output register.
// The divider, one quotient bit per stage, sets the depth.
// Synchronous active-low reset clears valid bits only; no state survives a request.
// A stalled output holds in m_angle; one more request lands in the skid register,
// and s_ready drops until the skid empties.
`default_nettype none

module atan2_polynomial_approx_core
    import atan2pa_pkg::*;
#(
    parameter int COMP_WIDTH      = COMP_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [COMP_WIDTH-1:0]   s_y_comp,
    input  wire logic signed [COMP_WIDTH-1:0]   s_x_comp,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [ANGLE_FRAC_BITS+2:0]   m_angle
);

    localparam int AW = ANGLE_FRAC_BITS + 3;

    localparam logic [63:0] PI_F64 =
        ((PI_Q29 << 1) + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_PI_F64 =
        (PI_Q29 + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    localparam logic signed [AW-1:0] PI_F      = PI_F64[AW-1:0];
    localparam logic signed [AW-1:0] HALF_PI_F = HALF_PI_F64[AW-1:0];

    logic en;

    // ---------------- operand prep ----------------
    logic [COMP_WIDTH-1:0] ax, ay;
    flags_t                prep_flags;
    logic                  prep_v_reg;
    flags_t                prep_f_reg;
    logic [COMP_WIDTH-1:0] prep_mn_reg, prep_mx_reg;

    // Unsigned magnitude; the most negative value maps to 2^(COMP_WIDTH-1) exactly
    assign ax = s_x_comp[COMP_WIDTH-1] ? (~s_x_comp + 1'b1) : s_x_comp;
    assign ay = s_y_comp[COMP_WIDTH-1] ? (~s_y_comp + 1'b1) : s_y_comp;

    assign prep_flags.x_zero = (s_x_comp == '0);
    assign prep_flags.x_neg  = s_x_comp[COMP_WIDTH-1];
    assign prep_flags.y_neg  = s_y_comp[COMP_WIDTH-1];
    assign prep_flags.y_pos  = !s_y_comp[COMP_WIDTH-1] && (s_y_comp != '0);
    assign prep_flags.swap   = (ay > ax);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_v_reg <= 1'b0;
        end else if (en) begin
            prep_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_f_reg  <= prep_flags;
            prep_mn_reg <= prep_flags.swap ? ax : ay;
            prep_mx_reg <= prep_flags.swap ? ay : ax;
        end
    end

    // ---------------- divider and polynomial ----------------
    logic                     div_v;
    flags_t                   div_f;
    logic [QUO_W-1:0]         div_a;
    logic                     poly_v;
    flags_t                   poly_f;
    logic [ANGLE_FRAC_BITS:0] poly_r;

    atan2pa_div #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_v_reg),
        .in_flags  (prep_f_reg),
        .in_mn     (prep_mn_reg),
        .in_mx     (prep_mx_reg),
        .out_valid (div_v),
        .out_flags (div_f),
        .out_quo   (div_a)
    );

    atan2pa_poly #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_v),
        .in_flags  (div_f),
        .in_a      (div_a),
        .out_valid (poly_v),
        .out_flags (poly_f),
        .out_r     (poly_r)
    );

    // ---------------- octant fix ----------------
    logic signed [AW-1:0] oct_r, oct_sw, oct_xn, oct_yn, angle_next;

    assign oct_r      = AW'(poly_r);
    assign oct_sw     = poly_f.swap  ? (HALF_PI_F - oct_r) : oct_r;
    assign oct_xn     = poly_f.x_neg ? (PI_F - oct_sw)     : oct_sw;
    assign oct_yn     = poly_f.y_neg ? -oct_xn             : oct_xn;
    assign angle_next = !poly_f.x_zero ? oct_yn
                      : (poly_f.y_pos ? HALF_PI_F : -HALF_PI_F);

    // ---------------- output register and skid ----------------
    logic                 m_valid_reg, m_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic signed [AW-1:0] m_angle_reg, m_angle_next;
    logic signed [AW-1:0] skid_angle_reg;
    logic                 out_free, push;

    // Pipeline advances only while the skid is empty
    assign en       = !skid_valid_reg;
    assign push     = en && poly_v;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_angle_next    = m_angle_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_angle_next    = skid_angle_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = push;
                m_angle_next = angle_next;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_angle_reg <= m_angle_next;
        if (!out_free && push) begin
            skid_angle_reg <= angle_next;
        end
    end

    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_angle = m_angle_reg;

    // ---------------- assertions ----------------
    // Skid fills or stays full only behind a stalled output
    a_skid_behind_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> $past(m_valid_reg && !m_ready))
        else $error("skid holds data without a stalled output");

    // A skid entry never leaves the output register empty
    a_skid_drains_to_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> m_valid_reg)
        else $error("skid entry lost");

    // Result always lies within -pi..pi
    a_angle_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_angle_reg <= PI_F) && (m_angle_reg >= -PI_F))
        else $error("angle outside -pi..pi");

endmodule

`default_nettype wire

[design/atan2pa_div.sv]
// Pipelined restoring divider: a = round(mn * 2^16 / mx), one quotient bit per stage.
// Depends on atan2pa_pkg (QUO_W, FRAC_W, flags_t).
`default_nettype none

module atan2pa_div
    import atan2pa_pkg::*;
#(
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire flags_t                in_flags,
    input  wire logic [COMP_WIDTH-1:0] in_mn,
    input  wire logic [COMP_WIDTH-1:0] in_mx,
    output logic                       out_valid,
    output flags_t                     out_flags,
    output logic [QUO_W-1:0]           out_quo
);

    localparam int NW = COMP_WIDTH + QUO_W;

    // Numerator with the half-divisor added for round-to-nearest
    logic [NW-1:0] num;
    assign num = NW'({in_mn, {FRAC_W{1'b0}}}) + NW'(in_mx >> 1);

    logic                  vld_reg [QUO_W];
    flags_t                flg_reg [QUO_W];
    logic [COMP_WIDTH-1:0] rem_reg [QUO_W];
    logic [COMP_WIDTH-1:0] mx_reg  [QUO_W];
    logic [QUO_W-1:0]      lo_reg  [QUO_W];
    logic [QUO_W-1:0]      q_reg   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                  v_i;
        flags_t                f_i;
        logic [COMP_WIDTH-1:0] rem_i;
        logic [COMP_WIDTH-1:0] mx_i;
        logic [QUO_W-1:0]      lo_i;
        logic [QUO_W-1:0]      q_i;
        logic [COMP_WIDTH:0]   sh;
        logic [COMP_WIDTH:0]   diff;
        logic                  ge;
        logic [COMP_WIDTH-1:0] rem_next;
        logic [QUO_W-1:0]      q_next;

        if (k == 0) begin : g_first
            // Top bits of the numerator are already below the divisor
            assign v_i   = in_valid;
            assign f_i   = in_flags;
            assign rem_i = num[NW-1 -: COMP_WIDTH];
            assign mx_i  = in_mx;
            assign lo_i  = num[QUO_W-1:0];
            assign q_i   = '0;
        end else begin : g_next
            assign v_i   = vld_reg[k-1];
            assign f_i   = flg_reg[k-1];
            assign rem_i = rem_reg[k-1];
            assign mx_i  = mx_reg[k-1];
            assign lo_i  = lo_reg[k-1];
            assign q_i   = q_reg[k-1];
        end

        assign sh       = {rem_i, lo_i[QUO_W-1]};
        assign diff     = sh - {1'b0, mx_i};
        assign ge       = (sh >= {1'b0, mx_i});
        assign rem_next = ge ? diff[COMP_WIDTH-1:0] : sh[COMP_WIDTH-1:0];
        assign q_next   = {q_i[QUO_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                flg_reg[k] <= f_i;
                rem_reg[k] <= rem_next;
                mx_reg[k]  <= mx_i;
                lo_reg[k]  <= {lo_i[QUO_W-2:0], 1'b0};
                q_reg[k]   <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_flags = flg_reg[QUO_W-1];
    assign out_quo   = q_reg[QUO_W-1];

endmodule

`default_nettype wire

[design/atan2pa_poly.sv]
// Six-stage polynomial pipeline: r = a + a*s*((c1*s + c2)*s - c3), s = a*a,
// then r scaled to the angle fraction width. Depends on atan2pa_pkg.
`default_nettype none

module atan2pa_poly
    import atan2pa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire flags_t                   in_flags,
    input  wire logic [QUO_W-1:0]         in_a,
    output logic                          out_valid,
    output flags_t                        out_flags,
    output logic [ANGLE_FRAC_BITS:0]      out_r
);

    localparam int WW = QUO_W + ANGLE_FRAC_BITS;

    // Scale a product back by 2^16, halves toward +infinity
    function automatic logic signed [PW-1:0] rnd16(input logic signed [2*PW-1:0] p);
        logic signed [2*PW-1:0] t;
        t = p + (2*PW)'(32768);
        return t[FRAC_W +: PW];
    endfunction

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    flags_t                   f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    logic signed [PW-1:0]     a1_reg, a2_reg, a3_reg, a4_reg, a5_reg;
    logic signed [PW-1:0]     s1_reg, s2_reg, s3_reg;
    logic signed [PW-1:0]     t2_reg, t3_reg, t4_reg, t5_reg;
    logic [ANGLE_FRAC_BITS:0] rf6_reg;

    logic signed [PW-1:0]     a0;
    logic signed [PW-1:0]     s1_next, t2_next, t3_next, t4_next, t5_next;
    logic signed [PW:0]       r_sum;
    logic [QUO_W-1:0]         r_mag;
    logic [WW-1:0]            r_wide;
    logic [ANGLE_FRAC_BITS:0] rf6_next;

    assign a0      = $signed({1'b0, in_a});
    assign s1_next = rnd16(a0 * a0);
    assign t2_next = rnd16(COEF_C1 * s1_reg) + COEF_C2;
    assign t3_next = rnd16(t2_reg * s2_reg) - COEF_C3;
    assign t4_next = rnd16(t3_reg * s3_reg);
    assign t5_next = rnd16(t4_reg * a4_reg);

    // r = a + t, clamp below at zero, then round to the angle fraction width
    assign r_sum    = {a5_reg[PW-1], a5_reg} + {t5_reg[PW-1], t5_reg};
    assign r_mag    = r_sum[PW] ? '0 : r_sum[QUO_W-1:0];
    assign r_wide   = {r_mag, {ANGLE_FRAC_BITS{1'b0}}} + WW'(32768);
    assign rf6_next = r_wide[FRAC_W +: ANGLE_FRAC_BITS + 1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg  <= in_flags;
            a1_reg  <= a0;
            s1_reg  <= s1_next;

            f2_reg  <= f1_reg;
            a2_reg  <= a1_reg;
            s2_reg  <= s1_reg;
            t2_reg  <= t2_next;

            f3_reg  <= f2_reg;
            a3_reg  <= a2_reg;
            s3_reg  <= s2_reg;
            t3_reg  <= t3_next;

            f4_reg  <= f3_reg;
            a4_reg  <= a3_reg;
            t4_reg  <= t4_next;

            f5_reg  <= f4_reg;
            a5_reg  <= a4_reg;
            t5_reg  <= t5_next;

            f6_reg  <= f5_reg;
            rf6_reg <= rf6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_flags = f6_reg;
    assign out_r     = rf6_reg;

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for atan2_polynomial_approx_core: random and corner vectors,
// angles predicted in fixed point and compared in order. Depends on atan2pa_pkg and the
// core RTL.
module tb
    import atan2pa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = COMP_WIDTH_DEF;
    localparam int AFB          = ANGLE_FRAC_BITS_DEF;
    localparam int AW           = AFB + 3;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 9;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 200;

    typedef struct {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
        logic signed [AW-1:0] angle;
    } angle_req_t;

    class angle_scoreboard;
        angle_req_t pending_angles[$];
        int         errors;

        // Round to nearest, halves toward +inf, then shift right arithmetically.
        static function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        static function logic signed [AW-1:0] predict_angle(logic signed [CW-1:0] y,
                                                          logic signed [CW-1:0] x);
            longint yi, xi, ax, ay, mn, mx, a, s, t, r, pi_f, half_pi_f, res;
            yi        = y;
            xi        = x;
            pi_f      = round_shift(longint'(PI_Q29) * 2, 30 - AFB);
            half_pi_f = round_shift(longint'(PI_Q29), 30 - AFB);
            if (xi == 0) begin
                res = (yi > 0) ? half_pi_f : -half_pi_f;
            end else begin
                ax = (xi < 0) ? -xi : xi;
                ay = (yi < 0) ? -yi : yi;
                mn = (ax < ay) ? ax : ay;
                mx = (ax < ay) ? ay : ax;
                a  = ((mn <<< FRAC_W) + (mx >>> 1)) / mx;
                if (a > (longint'(1) <<< FRAC_W))
                    a = longint'(1) <<< FRAC_W;
                s = round_shift(a * a, FRAC_W);
                t = round_shift(longint'(COEF_C1) * s, FRAC_W) + longint'(COEF_C2);
                t = round_shift(t * s, FRAC_W) - longint'(COEF_C3);
                t = round_shift(t * s, FRAC_W);
                t = round_shift(t * a, FRAC_W);
                r = a + t;
                if (r < 0)
                    r = 0;
                r = round_shift(r <<< AFB, FRAC_W);
                if (ay > ax)
                    r = half_pi_f - r;
                if (xi < 0)
                    r = pi_f - r;
                if (yi < 0)
                    r = -r;
                res = r;
            end
            return res[AW-1:0];
        endfunction

        function void note_request(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
            angle_req_t req;
            req.y     = y;
            req.x     = x;
            req.angle = predict_angle(y, x);
            pending_angles.push_back(req);
        endfunction

        function void check_angle(logic signed [AW-1:0] got);
            angle_req_t req;
            if (pending_angles.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: angle %0d with no request outstanding, expected none",
                             $time, got);
                return;
            end
            req = pending_angles.pop_front();
            if (got !== req.angle) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, actual %0d",
                             $time, req.y, req.x, req.angle, got);
            end
        endfunction

        function int outstanding();
            return pending_angles.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_y_comp;
    logic signed [CW-1:0] s_x_comp;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [AW-1:0] m_angle;

    angle_scoreboard sb = new();

    int gap_pct;
    int stall_pct;
    bit long_hold_req;

    always #CLK_HALF aclk = ~aclk;

    atan2_polynomial_approx_core #(
        .COMP_WIDTH      (CW),
        .ANGLE_FRAC_BITS (AFB)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_y_comp (s_y_comp),
        .s_x_comp (s_x_comp),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_angle  (m_angle)
    );

    // Both channels are sampled with pre-edge values.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1)
                sb.note_request(s_y_comp, s_x_comp);
            if (m_valid === 1'b1 && m_ready)
                sb.check_angle(m_angle);
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else if ($urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Call at a rising edge; returns at the edge where the request is taken.
    task automatic drive_request(input int y, input int x);
        s_valid  <= 1'b1;
        s_y_comp <= y[CW-1:0];
        s_x_comp <= x[CW-1:0];
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic random_request();
        int pick, y, x, d;
        pick = $urandom_range(9);
        y    = int'($urandom_range(65535)) - 32768;
        x    = int'($urandom_range(65535)) - 32768;
        if (pick == 5) begin
            y = y % 256;
            x = x % 256;
        end else if (pick == 6) begin
            if ($urandom_range(1))
                x = 0;
            else
                y = 0;
        end else if (pick == 7) begin
            // hug the octant boundary, where the ratio rounds to or near 1.0
            d = int'($urandom_range(4)) - 2;
            y = ($urandom_range(1) ? x : -x) + d;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
        end else if (pick == 8) begin
            y = $urandom_range(1) ? 32767 : -32768;
            if ($urandom_range(1))
                x = $urandom_range(1) ? -32768 : 32767;
        end else if (pick == 9) begin
            x = x % 8;
        end
        drive_request(y, x);
    endtask

    task automatic random_phase(input int count, input int gap, input int stall);
        gap_pct   = gap;
        stall_pct = stall;
        repeat (count) begin
            random_request();
            idle_gap();
        end
    endtask

    initial begin : stimulus
        int corner_y [24] = '{0, 1, -1, 32767, -32768, 0, 0, 0, 0, 5, 5, -5,
                              -5, -32768, 32767, -32768, 32767, 1, -32768, 1,
                              32767, -1, -32768, 12345};
        int corner_x [24] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, 5, -5, 5,
                              -5, -32768, 32767, 32767, -32768, -32768, 1, 32767,
                              1, -32768, -1, -23456};
        gap_pct       = 0;
        stall_pct     = 0;
        long_hold_req = 1'b0;
        aresetn  <= 1'b0;
        s_valid  <= 1'b0;
        s_y_comp <= '0;
        s_x_comp <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gap_pct   = 20;
        stall_pct = 10;
        foreach (corner_y[i]) begin
            drive_request(corner_y[i], corner_x[i]);
            idle_gap();
        end

        random_phase(300, 15, 8);

        // Hold the result side off while requests keep coming, so the core backs up.
        stall_pct     = 0;
        gap_pct       = 0;
        long_hold_req = 1'b1;
        repeat (120) random_request();

        // Pause until every outstanding angle has come back.
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);

        random_phase(200, 0, 0);
        random_phase(200, 40, 25);
        random_phase(200, 0, 0);

        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
